FILE: rtl/tdp_pkg.sv
// Shared types, codes and the divide-step function of the touch drag path generator.
// No dependencies; used by every other file of the block.
`default_nettype none
package tdp_pkg;

  // Touch phase codes
  localparam logic [1:0] PH_LAND = 2'd0;
  localparam logic [1:0] PH_MOVE = 2'd1;
  localparam logic [1:0] PH_LIFT = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_END_X    = 3'd2;
  localparam logic [2:0] REG_END_Y    = 3'd3;
  localparam logic [2:0] REG_STEPS    = 3'd4;
  localparam logic [2:0] REG_SPAN     = 3'd5;
  localparam logic [2:0] REG_PRESSURE = 3'd6;

  // Divider geometry: 8 quotient bits per stage
  localparam int DIV_BITS   = 8;
  localparam int GAP_W      = 48;
  localparam int POS_DIV_W  = 24;
  localparam int DIV_STAGES = GAP_W / DIV_BITS;
  localparam int POS_STAGES = POS_DIV_W / DIV_BITS;

  typedef struct packed {
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic [9:0]  end_x;
    logic [9:0]  end_y;
    logic [7:0]  step_count;
    logic [47:0] total_span;
    logic [7:0]  touch_pressure;
  } tdp_cfg_t;

  // One transaction travelling down the divider pipeline
  typedef struct packed {
    logic                 vld;
    logic                 ok;
    logic [1:0]           phase;
    logic [8:0]           den;
    logic [GAP_W-1:0]     gap_d;
    logic [8:0]           gap_rem;
    logic [POS_DIV_W-1:0] x_d;
    logic [8:0]           x_rem;
    logic [POS_DIV_W-1:0] y_d;
    logic [8:0]           y_rem;
  } tdp_pipe_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] q;
    logic [8:0]          rem;
  } tdp_div_t;

  // Eight restoring-division steps; rem stays below den (den <= 256)
  function automatic tdp_div_t div_step8(input logic [8:0] rem_in,
                                         input logic [DIV_BITS-1:0] bits,
                                         input logic [8:0] den);
    tdp_div_t   res;
    logic [9:0] r;
    logic [8:0] rem;
    rem = rem_in;
    res.q = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      r = {rem, bits[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        res.q[i] = 1'b1;
      end
      rem = r[8:0];
    end
    res.rem = rem;
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/touch_drag_path_generator.sv
// Top level of the touch drag path generator: configuration registers, pipeline, output.
// Depends on tdp_pkg, tdp_front and tdp_div_stage.
`default_nettype none
// Usage
//   Configuration: write cfg_index/cfg_wdata with cfg_valid; cfg_ready is always high.
//   Indexes 0..6 select start_x, start_y, end_x, end_y, step_count, total_span,
//   touch_pressure; other indexes are ignored. Write only while no transaction
//   is in flight.
//   Input: a transaction is taken when start is high and busy is low. busy is
//   always low, so one report index can be taken every clock cycle.
//   Output: each result appears for one cycle with out_valid high; results come
//   in input order.
//   The path runs through two front stages (products, rounding add), six divider
//   stages that each produce eight quotient bits of the gap, and the output
//   register; the position quotients finish within the first three dividers.
//   Reset (rst_n low, synchronous) restores the register defaults and drops
//   every transaction in flight. The receiver cannot stall; nothing is held.
//   Failed configuration or out-of-range index gives out_report_valid low
//   with all other result fields zero.
module touch_drag_path_generator #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 480,
  parameter int STEPS_LEAST  = 1,
  parameter int STEPS_MOST   = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [8:0]  in_report_index,
  output logic             out_valid,
  output logic             out_report_valid,
  output logic [9:0]       out_pos_x,
  output logic [9:0]       out_pos_y,
  output logic [1:0]       out_touch_phase,
  output logic [7:0]       out_pressure_out,
  output logic [47:0]      out_report_gap,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);

  localparam int NS = tdp_pkg::DIV_STAGES;

  tdp_pkg::tdp_cfg_t  cfg_r;
  tdp_pkg::tdp_pipe_t pipe [NS+1];

  logic        out_valid_r;
  logic        ok_r;
  logic [9:0]  pos_x_r;
  logic [9:0]  pos_y_r;
  logic [1:0]  phase_r;
  logic [7:0]  pressure_r;
  logic [47:0] gap_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x        <= '0;
      cfg_r.start_y        <= '0;
      cfg_r.end_x          <= '0;
      cfg_r.end_y          <= '0;
      cfg_r.step_count     <= 8'd1;
      cfg_r.total_span     <= '0;
      cfg_r.touch_pressure <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tdp_pkg::REG_START_X:  cfg_r.start_x        <= cfg_wdata[9:0];
        tdp_pkg::REG_START_Y:  cfg_r.start_y        <= cfg_wdata[9:0];
        tdp_pkg::REG_END_X:    cfg_r.end_x          <= cfg_wdata[9:0];
        tdp_pkg::REG_END_Y:    cfg_r.end_y          <= cfg_wdata[9:0];
        tdp_pkg::REG_STEPS:    cfg_r.step_count     <= cfg_wdata[7:0];
        tdp_pkg::REG_SPAN:     cfg_r.total_span     <= cfg_wdata;
        tdp_pkg::REG_PRESSURE: cfg_r.touch_pressure <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  tdp_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT),
    .STEPS_LEAST (STEPS_LEAST),
    .STEPS_MOST  (STEPS_MOST)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (start && !busy),
    .report_index(in_report_index),
    .cfg         (cfg_r),
    .pipe_o      (pipe[0])
  );

  // Divider chain
  for (genvar s = 0; s < NS; s++) begin : g_div
    tdp_div_stage #(
      .DO_POS(s < tdp_pkg::POS_STAGES)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .pipe_i(pipe[s]),
      .pipe_o(pipe[s+1])
    );
  end

  // Output register; fields are zero on a rejected report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pipe[NS].vld;
    end
    ok_r       <= pipe[NS].ok;
    pos_x_r    <= pipe[NS].ok ? pipe[NS].x_d[9:0] : '0;
    pos_y_r    <= pipe[NS].ok ? pipe[NS].y_d[9:0] : '0;
    phase_r    <= pipe[NS].ok ? pipe[NS].phase : tdp_pkg::PH_LAND;
    pressure_r <= (pipe[NS].ok && pipe[NS].phase != tdp_pkg::PH_LIFT)
                  ? cfg_r.touch_pressure : '0;
    gap_r      <= pipe[NS].ok ? pipe[NS].gap_d : '0;
  end

  assign out_valid        = out_valid_r;
  assign out_report_valid = ok_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_touch_phase  = phase_r;
  assign out_pressure_out = pressure_r;
  assign out_report_gap   = gap_r;

endmodule
`default_nettype wire

FILE: rtl/tdp_front.sv
// Front end: checks, phase decode, scaling products and the rounded dividend.
// Depends on tdp_pkg.
`default_nettype none
module tdp_front #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 480,
  parameter int STEPS_LEAST  = 1,
  parameter int STEPS_MOST   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [8:0]        report_index,
  input  wire tdp_pkg::tdp_cfg_t cfg,
  output tdp_pkg::tdp_pipe_t     pipe_o
);

  logic [8:0]         den;
  logic [9:0]         reports;
  logic               cfg_ok;
  logic               ok_nxt;
  logic [1:0]         phase_nxt;
  logic signed [10:0] dx;
  logic signed [10:0] dy;

  logic               vld1_r;
  logic               ok1_r;
  logic [1:0]         phase1_r;
  logic [18:0]        ax_r;
  logic [18:0]        ay_r;
  logic signed [20:0] px_r;
  logic signed [20:0] py_r;

  logic signed [21:0] sx;
  logic signed [21:0] sy;
  logic [18:0]        mx;
  logic [18:0]        my;
  tdp_pkg::tdp_pipe_t pipe_r;

  assign den     = {1'b0, cfg.step_count} + 9'd1;
  assign reports = {2'b0, cfg.step_count} + 10'd2;

  // Configuration and index checks
  always_comb begin
    cfg_ok = ({1'b0, cfg.step_count} >= 9'(STEPS_LEAST))
          && ({1'b0, cfg.step_count} <= 9'(STEPS_MOST))
          && ({1'b0, cfg.start_x} < 11'(PANEL_WIDTH))
          && ({1'b0, cfg.end_x} < 11'(PANEL_WIDTH))
          && ({1'b0, cfg.start_y} < 11'(PANEL_HEIGHT))
          && ({1'b0, cfg.end_y} < 11'(PANEL_HEIGHT))
          && (cfg.total_span >= {39'd0, den});
    ok_nxt = cfg_ok && ({1'b0, report_index} < reports);
  end

  // Phase decode
  always_comb begin
    if (report_index == 9'd0) begin
      phase_nxt = tdp_pkg::PH_LAND;
    end else if (report_index == den) begin
      phase_nxt = tdp_pkg::PH_LIFT;
    end else begin
      phase_nxt = tdp_pkg::PH_MOVE;
    end
  end

  assign dx = $signed({1'b0, cfg.end_x}) - $signed({1'b0, cfg.start_x});
  assign dy = $signed({1'b0, cfg.end_y}) - $signed({1'b0, cfg.start_y});

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_fire;
    end
    ok1_r    <= ok_nxt;
    phase1_r <= phase_nxt;
    ax_r     <= cfg.start_x * den;
    ay_r     <= cfg.start_y * den;
    px_r     <= dx * $signed({1'b0, report_index});
    py_r     <= dy * $signed({1'b0, report_index});
  end

  // Stage 2: start*den + delta*k + den/2, later floored by den
  assign sx = $signed({3'b0, ax_r}) + 22'(px_r);
  assign sy = $signed({3'b0, ay_r}) + 22'(py_r);
  assign mx = sx[18:0] + {11'd0, den[8:1]};
  assign my = sy[18:0] + {11'd0, den[8:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r.vld <= vld1_r;
    end
    pipe_r.ok      <= ok1_r;
    pipe_r.phase   <= phase1_r;
    pipe_r.den     <= den;
    pipe_r.gap_d   <= cfg.total_span;
    pipe_r.gap_rem <= '0;
    pipe_r.x_d     <= {5'd0, mx};
    pipe_r.x_rem   <= '0;
    pipe_r.y_d     <= {5'd0, my};
    pipe_r.y_rem   <= '0;
  end

  assign pipe_o = pipe_r;

endmodule
`default_nettype wire

FILE: rtl/tdp_div_stage.sv
// One divider stage: eight quotient bits of the gap and, optionally, of both positions.
// Depends on tdp_pkg.
`default_nettype none
module tdp_div_stage #(
  parameter bit DO_POS = 1'b1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tdp_pkg::tdp_pipe_t pipe_i,
  output tdp_pkg::tdp_pipe_t      pipe_o
);

  localparam int B = tdp_pkg::DIV_BITS;
  localparam int G = tdp_pkg::GAP_W;
  localparam int P = tdp_pkg::POS_DIV_W;

  tdp_pkg::tdp_div_t  gq;
  tdp_pkg::tdp_div_t  xq;
  tdp_pkg::tdp_div_t  yq;
  tdp_pkg::tdp_pipe_t pipe_r;

  // Top bits are consumed, quotient bits shift in at the bottom
  assign gq = tdp_pkg::div_step8(pipe_i.gap_rem, pipe_i.gap_d[G-1 -: B], pipe_i.den);
  assign xq = tdp_pkg::div_step8(pipe_i.x_rem, pipe_i.x_d[P-1 -: B], pipe_i.den);
  assign yq = tdp_pkg::div_step8(pipe_i.y_rem, pipe_i.y_d[P-1 -: B], pipe_i.den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.vld <= 1'b0;
    end else begin
      pipe_r.vld <= pipe_i.vld;
    end
    pipe_r.ok      <= pipe_i.ok;
    pipe_r.phase   <= pipe_i.phase;
    pipe_r.den     <= pipe_i.den;
    pipe_r.gap_d   <= {pipe_i.gap_d[G-B-1:0], gq.q};
    pipe_r.gap_rem <= gq.rem;
    if (DO_POS) begin
      pipe_r.x_d   <= {pipe_i.x_d[P-B-1:0], xq.q};
      pipe_r.x_rem <= xq.rem;
      pipe_r.y_d   <= {pipe_i.y_d[P-B-1:0], yq.q};
      pipe_r.y_rem <= yq.rem;
    end else begin
      pipe_r.x_d   <= pipe_i.x_d;
      pipe_r.x_rem <= pipe_i.x_rem;
      pipe_r.y_d   <= pipe_i.y_d;
      pipe_r.y_rem <= pipe_i.y_rem;
    end
  end

  assign pipe_o = pipe_r;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for touch_drag_path_generator: directed table, then random gestures.
// Depends on tdp_pkg and the touch_drag_path_generator RTL; needs nothing else.
`timescale 1ns / 1ps
module tb;

  localparam int PANEL_W    = 320;
  localparam int PANEL_H    = 480;
  localparam int STEPS_MIN  = 1;
  localparam int STEPS_MAX  = 64;
  localparam int LATENCY    = 9;
  localparam int CYCLE_CAP  = 500000;
  localparam int RAND_ITEMS = 1950;

  typedef struct packed {
    logic        ok;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [1:0]  phase;
    logic [7:0]  pres;
    logic [47:0] gap;
  } touch_report_t;

  typedef struct {
    logic [8:0]    k;
    bit            typed;
    touch_report_t r;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [8:0]  in_report_index;
  logic        out_valid;
  logic        out_report_valid;
  logic [9:0]  out_pos_x;
  logic [9:0]  out_pos_y;
  logic [1:0]  out_touch_phase;
  logic [7:0]  out_pressure_out;
  logic [47:0] out_report_gap;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_wdata;

  // Register shadow of the block
  logic [9:0]  g_sx, g_sy, g_ex, g_ey;
  logic [7:0]  g_steps;
  logic [47:0] g_span;
  logic [7:0]  g_pres;

  touch_report_t expected_reports[$];
  dir_row_t      dir_rows[$];
  touch_report_t forced_exp;
  bit            use_forced;
  int            errors;
  int            cycles;
  int            n_items;
  int            n_valid;
  int            n_cfg;

  touch_drag_path_generator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_report_index(in_report_index),
    .out_valid(out_valid), .out_report_valid(out_report_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_touch_phase(out_touch_phase), .out_pressure_out(out_pressure_out),
    .out_report_gap(out_report_gap),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounded-half-up point on the line from a to b at k/den
  function automatic logic [9:0] lerp_pos(logic [9:0] a, logic [9:0] b, int k, int den);
    longint scaled;
    longint q;
    scaled = longint'(a) * den + (longint'(b) - longint'(a)) * k;
    q = (2 * scaled + den) / (2 * den);
    return q[9:0];
  endfunction

  function automatic touch_report_t predict_report(logic [8:0] k);
    touch_report_t r;
    bit            cfg_good;
    int            den;
    r = '0;
    den = int'(g_steps) + 1;
    cfg_good = (g_steps >= STEPS_MIN) && (g_steps <= STEPS_MAX) &&
               (g_sx < PANEL_W) && (g_ex < PANEL_W) &&
               (g_sy < PANEL_H) && (g_ey < PANEL_H) &&
               ({1'b0, g_span} >= 49'(den));
    if (!cfg_good || int'(k) > den) return r;
    r.ok = 1'b1;
    r.x = lerp_pos(g_sx, g_ex, int'(k), den);
    r.y = lerp_pos(g_sy, g_ey, int'(k), den);
    r.phase = (k == 0) ? tdp_pkg::PH_LAND
                       : ((int'(k) == den) ? tdp_pkg::PH_LIFT : tdp_pkg::PH_MOVE);
    r.pres = (r.phase == tdp_pkg::PH_LIFT) ? 8'd0 : g_pres;
    r.gap = g_span / 48'(den);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
  endtask

  // Acceptance, result checking and the run limit
  always @(posedge clk) begin
    touch_report_t w;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_n && start && !busy) begin
        expected_reports.push_back(use_forced ? forced_exp : predict_report(in_report_index));
        n_items++;
      end
      if (rst_n && out_valid) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = expected_reports.pop_front();
          if (w.ok) n_valid++;
          if (out_report_valid !== w.ok) report_mismatch("report_valid", out_report_valid, w.ok);
          if (out_pos_x !== w.x) report_mismatch("pos_x", out_pos_x, w.x);
          if (out_pos_y !== w.y) report_mismatch("pos_y", out_pos_y, w.y);
          if (out_touch_phase !== w.phase)
            report_mismatch("touch_phase", out_touch_phase, w.phase);
          if (out_pressure_out !== w.pres)
            report_mismatch("pressure_out", out_pressure_out, w.pres);
          if (out_report_gap !== w.gap) report_mismatch("report_gap", out_report_gap, w.gap);
        end
      end
    end
  end

  // One register write; upper data bits are random noise that the block must mask
  task automatic cfg_write(logic [2:0] idx, logic [47:0] v, int w);
    logic [47:0] data;
    logic [47:0] m;
    m = (w >= 48) ? '1 : ((48'd1 << w) - 48'd1);
    data = {$urandom, $urandom};
    data = (data & ~m) | (v & m);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tdp_pkg::REG_START_X:  g_sx = data[9:0];
      tdp_pkg::REG_START_Y:  g_sy = data[9:0];
      tdp_pkg::REG_END_X:    g_ex = data[9:0];
      tdp_pkg::REG_END_Y:    g_ey = data[9:0];
      tdp_pkg::REG_STEPS:    g_steps = data[7:0];
      tdp_pkg::REG_SPAN:     g_span = data;
      tdp_pkg::REG_PRESSURE: g_pres = data[7:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_gesture(int sx, int sy, int ex, int ey, int st, logic [47:0] sp, int pr);
    cfg_write(tdp_pkg::REG_START_X, 48'(sx), 10);
    cfg_write(tdp_pkg::REG_START_Y, 48'(sy), 10);
    cfg_write(tdp_pkg::REG_END_X, 48'(ex), 10);
    cfg_write(tdp_pkg::REG_END_Y, 48'(ey), 10);
    cfg_write(tdp_pkg::REG_STEPS, 48'(st), 8);
    cfg_write(tdp_pkg::REG_SPAN, sp, 48);
    cfg_write(tdp_pkg::REG_PRESSURE, 48'(pr), 8);
    // index beyond the list must be ignored
    if ($urandom_range(0, 1)) cfg_write(3'd7, {$urandom, $urandom}, 48);
  endtask

  task automatic send_report(logic [8:0] k, bit typed, touch_report_t r, bit idle_ok);
    @(negedge clk);
    start = 1'b1;
    in_report_index = k;
    use_forced = typed;
    forced_exp = r;
    do @(posedge clk); while (busy);
    if (idle_ok && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Wait until every expected result has arrived, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    use_forced = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic add_row(int k, bit typed, touch_report_t r);
    dir_row_t row;
    row.k = 9'(k);
    row.typed = typed;
    row.r = r;
    dir_rows.push_back(row);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) send_report(dir_rows[i].k, dir_rows[i].typed, dir_rows[i].r, 1'b0);
    dir_rows.delete();
    drain();
  endtask

  initial begin
    touch_report_t none;
    touch_report_t r;
    int st;
    int phases;
    logic [47:0] sp;
    none = '0;
    errors = 0; cycles = 0; n_items = 0; n_valid = 0; n_cfg = 0;
    rst_n = 1'b0; start = 1'b0; in_report_index = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_wdata = '0;
    use_forced = 1'b0; forced_exp = '0;
    g_sx = 0; g_sy = 0; g_ex = 0; g_ey = 0; g_steps = 8'd1; g_span = 0; g_pres = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset the span is zero, so every report is rejected
    add_row(0, 1, none);
    add_row(2, 1, none);
    run_rows();

    // Corner-to-corner drag with the most steps and the largest span
    set_gesture(0, 0, PANEL_W - 1, PANEL_H - 1, STEPS_MAX, '1, 255);
    r = '{1'b1, 10'd0, 10'd0, tdp_pkg::PH_LAND, 8'd255, 48'h03F0_3F03_F03F};
    add_row(0, 1, r);
    r = '{1'b1, 10'(PANEL_W - 1), 10'(PANEL_H - 1), tdp_pkg::PH_LIFT, 8'd0,
          48'h03F0_3F03_F03F};
    add_row(STEPS_MAX + 1, 1, r);
    add_row(STEPS_MAX + 2, 1, none);
    add_row(256, 1, none);
    add_row(511, 1, none);
    add_row(1, 0, none);
    add_row(32, 0, none);
    add_row(STEPS_MAX, 0, none);
    run_rows();

    // Reverse drag, fewest steps, span exactly at its minimum
    set_gesture(PANEL_W - 1, PANEL_H - 1, 0, 0, STEPS_MIN, 48'(STEPS_MIN + 1), 0);
    add_row(0, 0, none);
    add_row(1, 0, none);
    add_row(2, 0, none);
    add_row(3, 1, none);
    run_rows();

    // Five configuration checks, each failing on its own
    set_gesture(5, 5, 9, 9, 0, 48'd100, 7);                 // too few steps
    add_row(0, 1, none);
    run_rows();
    cfg_write(tdp_pkg::REG_STEPS, 48'(STEPS_MAX + 1), 8);   // too many steps
    add_row(0, 1, none);
    run_rows();
    cfg_write(tdp_pkg::REG_STEPS, 48'd4, 8);
    cfg_write(tdp_pkg::REG_SPAN, 48'd4, 48);                // span below steps + 1
    add_row(1, 1, none);
    run_rows();
    cfg_write(tdp_pkg::REG_SPAN, 48'd5, 48);
    cfg_write(tdp_pkg::REG_START_X, 48'(PANEL_W), 10);      // off the panel in x
    add_row(0, 1, none);
    run_rows();
    cfg_write(tdp_pkg::REG_START_X, 48'd3, 10);
    cfg_write(tdp_pkg::REG_END_Y, 48'(PANEL_H), 10);        // off the panel in y
    add_row(0, 1, none);
    add_row(2, 0, none);
    run_rows();

    // Random gestures: mostly legal, with index mostly inside the gesture
    phases = 0;
    while (n_items < RAND_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        st = $urandom_range(0, 255);
        sp = {$urandom, $urandom};
        if ($urandom_range(0, 1)) sp = 48'($urandom_range(0, 300));
        set_gesture($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), st, sp, $urandom_range(0, 255));
      end else begin
        st = ($urandom_range(0, 3) == 0) ? $urandom_range(STEPS_MIN, STEPS_MAX)
                                         : $urandom_range(STEPS_MIN, 12);
        case ($urandom_range(0, 3))
          0: sp = 48'(st + 1 + $urandom_range(0, 3));
          1: sp = '1;
          default: sp = {$urandom, $urandom};
        endcase
        if (sp < 48'(st + 1)) sp = 48'(st + 1);
        set_gesture($urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1),
                    $urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1),
                    st, sp, $urandom_range(0, 255));
      end
      repeat ($urandom_range(40, 120)) begin
        if (n_items < RAND_ITEMS) begin
          if ($urandom_range(0, 9) == 0)
            send_report(9'($urandom), 1'b0, none, n_items < RAND_ITEMS - 150);
          else
            send_report(9'($urandom_range(0, int'(g_steps) + 1)), 1'b0, none,
                        n_items < RAND_ITEMS - 150);
        end
      end
      drain();
      phases++;
    end

    $display("covered %0d reports (%0d accepted as valid) over %0d gestures, %0d register writes",
             n_items, n_valid, phases, n_cfg);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
